>>> hw/rtl/kofn_det_pkg.sv
// shared types and constants for the k-of-n event detector with hold-off
package kofn_det_pkg;

  // length of the sliding hit window in frames (1 to 32)
  localparam int WINDOW_LEN = 15;

  // exact mark count width, and a width that also holds the saturation limit
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int CNT_WIDE_W = (CNT_W > 4) ? CNT_W : 4;

  // field widths
  localparam int PROB_W  = 17;
  localparam int MINH_W  = 4;
  localparam int HOLD_W  = 8;
  localparam int EVT_W   = 32;
  localparam int HITS_W  = 4;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 2;

  // Q0.16 full scale and count saturation
  localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(65536);
  localparam logic [HITS_W-1:0] COUNT_MAX = HITS_W'(15);

  // register reset values
  localparam logic [PROB_W-1:0] THRESH_RST = PROB_W'(32768);
  localparam logic [MINH_W-1:0] MINH_RST   = MINH_W'(2);
  localparam logic [HOLD_W-1:0] HOLD_RST   = HOLD_W'(66);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIT_THRESHOLD  = 2'd0,
    REG_HITS_NEEDED    = 2'd1,
    REG_HOLDOFF_FRAMES = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  // one result beat
  typedef struct packed {
    logic              detected;
    logic [EVT_W-1:0]  event_total;
    logic [PROB_W-1:0] peak_level;
    logic              report_valid;
    logic [HITS_W-1:0] window_hits;
  } result_t;

  // clamp an exact mark count to the reported range
  function automatic logic [HITS_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_WIDE_W-1:0] wide;
    logic [HITS_W-1:0]     res;
    wide = CNT_WIDE_W'(cnt);
    if (wide > CNT_WIDE_W'(COUNT_MAX)) begin
      res = COUNT_MAX;
    end else begin
      res = wide[HITS_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/k_of_n_event_detector_with_holdoff.sv
// k-of-n event detector with hold-off: top level
// Usage:
//   Input channel (in_valid / in_ready) carries one classifier frame per beat:
//   probability in unsigned Q0.16 (values above 1.0 are clamped) and
//   report_due. Output channel (out_valid / out_ready) returns exactly one
//   result beat per input beat, in order: detected, event_total, peak_level,
//   report_valid and window_hits.
//   Registers hit_threshold, hits_needed and holdoff_frames are written
//   through cfg_we / cfg_index / cfg_data; write them only while the block is idle.
// Timing:
//   The whole frame update is one short combinational pass into the state
//   and result registers, so each result is registered in the output register,
//   or in the skid register while the output stalls, and one frame is taken every cycle when the receiver keeps up.
//   A two-entry result buffer (output register plus skid register) lets the
//   block take another frame while a result waits; in_ready drops only when
//   both entries are full, and rises again as soon as the receiver takes one.
// Reset:
//   rst is synchronous; it clears window, counts, hold-off, peak and the
//   result buffer, loads the register defaults (0.5, 2, 66), and holds
//   in_ready low while asserted.
module k_of_n_event_detector_with_holdoff (
  input  logic                                 clk,
  input  logic                                 rst,
  // frame input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [kofn_det_pkg::PROB_W-1:0]      probability,
  input  logic                                 report_due,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 detected,
  output logic [kofn_det_pkg::EVT_W-1:0]       event_total,
  output logic [kofn_det_pkg::PROB_W-1:0]      peak_level,
  output logic                                 report_valid,
  output logic [kofn_det_pkg::HITS_W-1:0]      window_hits,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [kofn_det_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kofn_det_pkg::CFG_W-1:0]       cfg_data
);

  localparam int WL = kofn_det_pkg::WINDOW_LEN;

  // configuration registers
  logic [kofn_det_pkg::PROB_W-1:0] hit_threshold;
  logic [kofn_det_pkg::MINH_W-1:0] hits_needed;
  logic [kofn_det_pkg::HOLD_W-1:0] holdoff_frames;

  // detector state
  logic [WL-1:0]                   hit_window;
  logic [kofn_det_pkg::CNT_W-1:0]  hit_counter;
  logic [kofn_det_pkg::HOLD_W-1:0] holdoff_left;
  logic [kofn_det_pkg::EVT_W-1:0]  event_counter;
  logic [kofn_det_pkg::PROB_W-1:0] peak_hold;

  // result buffer
  kofn_det_pkg::result_t out_res;
  kofn_det_pkg::result_t skid_res;
  logic                  skid_valid;

  // frame datapath
  logic [kofn_det_pkg::PROB_W-1:0] prob_sat;
  logic [kofn_det_pkg::PROB_W-1:0] peak_next;
  logic                            hot;
  logic [WL:0]                     win_ext;
  logic [WL-1:0]                   win_shift;
  logic [kofn_det_pkg::CNT_W-1:0]  count_next;
  logic [kofn_det_pkg::HITS_W-1:0] count_sat;
  logic                            fire;
  kofn_det_pkg::result_t           res_next;
  logic                            accept;
  logic                            out_fire;

  assign accept   = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = !skid_valid && !rst;

  // clamp, peak tracking and hit test
  always_comb begin
    prob_sat  = (probability > kofn_det_pkg::PROB_ONE) ? kofn_det_pkg::PROB_ONE : probability;
    peak_next = (prob_sat > peak_hold) ? prob_sat : peak_hold;
    hot       = (prob_sat >= hit_threshold);
  end

  // window shift and running count: new mark in, oldest mark out
  always_comb begin
    win_ext    = {hit_window, hot};
    win_shift  = win_ext[WL-1:0];
    count_next = hit_counter + kofn_det_pkg::CNT_W'(hot)
                 - kofn_det_pkg::CNT_W'(hit_window[WL-1]);
    count_sat  = kofn_det_pkg::sat_count(count_next);
  end

  // event decision and result assembly
  always_comb begin
    fire = (holdoff_left == '0) && (count_sat >= hits_needed);
    res_next.detected     = fire;
    res_next.event_total  = fire ? (event_counter + kofn_det_pkg::EVT_W'(1)) : event_counter;
    res_next.peak_level   = peak_next;
    res_next.report_valid = report_due;
    res_next.window_hits  = fire ? '0 : count_sat;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold  <= kofn_det_pkg::THRESH_RST;
      hits_needed    <= kofn_det_pkg::MINH_RST;
      holdoff_frames <= kofn_det_pkg::HOLD_RST;
    end else if (cfg_we) begin
      unique case (kofn_det_pkg::cfg_reg_t'(cfg_index))
        kofn_det_pkg::REG_HIT_THRESHOLD:  hit_threshold  <= cfg_data;
        kofn_det_pkg::REG_HITS_NEEDED:    hits_needed    <= cfg_data[kofn_det_pkg::MINH_W-1:0];
        kofn_det_pkg::REG_HOLDOFF_FRAMES: holdoff_frames <= cfg_data[kofn_det_pkg::HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // detector state update per accepted frame
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_window    <= '0;
      hit_counter   <= '0;
      holdoff_left  <= '0;
      event_counter <= '0;
      peak_hold     <= '0;
    end else if (accept) begin
      peak_hold <= report_due ? '0 : peak_next;
      if (holdoff_left != '0) begin
        holdoff_left <= holdoff_left - kofn_det_pkg::HOLD_W'(1);
        hit_window   <= win_shift;
        hit_counter  <= count_next;
      end else if (fire) begin
        holdoff_left  <= holdoff_frames;
        event_counter <= res_next.event_total;
        hit_window    <= '0;
        hit_counter   <= '0;
      end else begin
        hit_window  <= win_shift;
        hit_counter <= count_next;
      end
    end
  end

  // result buffer: output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_valid && !out_ready) begin
        skid_res <= res_next;
      end else begin
        out_res <= res_next;
      end
    end else if (out_fire && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign detected     = out_res.detected;
  assign event_total  = out_res.event_total;
  assign peak_level   = out_res.peak_level;
  assign report_valid = out_res.report_valid;
  assign window_hits  = out_res.window_hits;

  // running count always matches the marks in the window
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    hit_counter == kofn_det_pkg::CNT_W'($countones(hit_window)))
    else $error("hit counter out of step with window");

  // skid entry only holds data behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // an event loads the hold-off and clears the window
  a_fire_load: assert property (@(posedge clk) disable iff (rst)
    accept && fire |=> holdoff_left == $past(holdoff_frames) && hit_window == '0)
    else $error("event did not load hold-off or clear window");

  // event counter moves only on an accepted frame that fires
  a_evt_stable: assert property (@(posedge clk) disable iff (rst)
    !(accept && fire) |=> $stable(event_counter))
    else $error("event counter changed without an event");

  // a detection result always reports an empty window
  a_det_hits: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.detected |-> out_res.window_hits == '0)
    else $error("detection with nonzero window hits");

endmodule
